// File: rtl/tns_pkg.sv
// tns_pkg: shared types and constants for the tachometer needle smoother.
// Used by the core and its checker. No dependencies.
package tns_pkg;

  // Default sizing.
  localparam int FRAC_BITS_DEF    = 8;
  localparam int SWEEP_TENTHS_DEF = 1800;

  // Field widths.
  localparam int RPM_W     = 16;
  localparam int ANGLE_W   = 11;
  localparam int ZONE_W    = 2;
  localparam int READOUT_W = 17;
  localparam int QUOT_W    = ANGLE_W + 1;   // one spare bit flags overflow
  localparam int ANGLE_MAX = (1 << ANGLE_W) - 1;

  // Register file.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_GAUGE_MAX = 2'd0;
  localparam logic [1:0] REG_AMBER     = 2'd1;
  localparam logic [1:0] REG_REDLINE   = 2'd2;
  localparam logic [RPM_W-1:0] GAUGE_MAX_RST = 16'd14000;
  localparam logic [RPM_W-1:0] AMBER_RST     = 16'd10000;
  localparam logic [RPM_W-1:0] REDLINE_RST   = 16'd12000;

  // Smoothing and readout.
  localparam int SNAP_RPM     = 5;
  localparam int READOUT_HALF = 50;
  localparam int READOUT_STEP = 100;
  // floor(y/100) == (y * RECIP_MUL) >> RECIP_SHIFT for y < 91000
  localparam int RECIP_MUL    = 83887;
  localparam int RECIP_SHIFT  = 23;
  localparam int RDQ_W        = 10;

  // Zone codes.
  localparam logic [ZONE_W-1:0] ZONE_NORMAL = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_AMBER  = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_RED    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_SCALE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// File: rtl/tachometer_needle_smoother_core.sv
// Tachometer needle smoother, top level: register file, sequencer, smoothing
// datapath and output register. Depends on tns_pkg and tns_div.
//
//   channel  | ports                           | direction | moves
//   ---------+---------------------------------+-----------+------------------------
//   in_      | in_valid/in_ready               | sink      | one raw rpm sample
//   out_     | out_valid/out_ready             | source    | angle, zone, readout,
//            |                                 |           | shift light + flags
//   config   | psel/penable/pwrite/paddr/...   | slave     | three 16-bit registers
//
// Per item, from input transfer to result loaded: smooth, scale multiplies,
// divider load, 12 divider steps, divider done handoff, finish; the divide
// is a 12-step restoring divide by the configured full scale.
// A zero full scale skips the divide and goes from divider load to finish.
// One item at a time: in_ready is high only while the sequencer idles, so
// a new sample is not taken until the last one has passed the finish step.
// The output register decouples the sides: a new sample is taken while a
// result still waits; the finish step holds until that register is free.
// Reset (synchronous, rst_n low) restores register defaults, zeroes the
// smoothed speed and history, so every changed flag is set on the first item.
module tachometer_needle_smoother_core #(
  parameter int FRAC_BITS    = tns_pkg::FRAC_BITS_DEF,
  parameter int SWEEP_TENTHS = tns_pkg::SWEEP_TENTHS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tns_pkg::RPM_W-1:0]           in_rpm_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tns_pkg::ANGLE_W-1:0]         out_needle_angle,
  output logic                                out_angle_changed,
  output logic [tns_pkg::ZONE_W-1:0]          out_speed_zone,
  output logic                                out_zone_changed,
  output logic [tns_pkg::READOUT_W-1:0]       out_readout_value,
  output logic                                out_readout_changed,
  output logic                                out_shift_light,
  output logic                                out_shift_changed,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tns_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [tns_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [tns_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int RW    = tns_pkg::RPM_W;
  localparam int SW_W  = RW + FRAC_BITS;                 // smoothed speed width
  localparam int SWW   = $clog2(SWEEP_TENTHS + 1);
  localparam int PW    = SW_W + SWW;                     // speed * sweep
  localparam int QW    = tns_pkg::QUOT_W;
  localparam int WW    = ((PW + 2) > (SW_W + QW)) ? (PW + 2) : (SW_W + QW);
  localparam int LIM   = (SWEEP_TENTHS > tns_pkg::ANGLE_MAX) ?
                         tns_pkg::ANGLE_MAX : SWEEP_TENTHS;
  localparam int RDP_W = 2 * tns_pkg::READOUT_W;

  // ---------------- register file ----------------
  logic [RW-1:0] gmax_r, amber_r, red_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gmax_r  <= tns_pkg::GAUGE_MAX_RST;
      amber_r <= tns_pkg::AMBER_RST;
      red_r   <= tns_pkg::REDLINE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        tns_pkg::REG_GAUGE_MAX: gmax_r  <= pwdata[RW-1:0];
        tns_pkg::REG_AMBER:     amber_r <= pwdata[RW-1:0];
        tns_pkg::REG_REDLINE:   red_r   <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tns_pkg::REG_GAUGE_MAX: prdata = tns_pkg::CFG_DATA_W'(gmax_r);
      tns_pkg::REG_AMBER:     prdata = tns_pkg::CFG_DATA_W'(amber_r);
      tns_pkg::REG_REDLINE:   prdata = tns_pkg::CFG_DATA_W'(red_r);
      default:                prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  tns_pkg::state_t state_r, state_nxt;
  logic            div_start, div_done;
  logic [QW-1:0]   div_quot;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tns_pkg::ST_IDLE:   if (in_valid) state_nxt = tns_pkg::ST_SMOOTH;
      tns_pkg::ST_SMOOTH: state_nxt = tns_pkg::ST_SCALE;
      tns_pkg::ST_SCALE:  state_nxt = tns_pkg::ST_LOAD;
      // zero full scale: no divide, angle forced to zero
      tns_pkg::ST_LOAD:   state_nxt = (gmax_r == '0) ? tns_pkg::ST_DONE : tns_pkg::ST_DIV;
      tns_pkg::ST_DIV:    if (div_done) state_nxt = tns_pkg::ST_DONE;
      tns_pkg::ST_DONE:   if (out_free) state_nxt = tns_pkg::ST_IDLE;
      default:            state_nxt = tns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == tns_pkg::ST_IDLE);
    div_start = (state_r == tns_pkg::ST_LOAD) && (gmax_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tns_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- sample capture (clamped to full scale) ----------------
  logic [RW-1:0] rpm_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rpm_r <= (in_rpm_sample > gmax_r) ? gmax_r : in_rpm_sample;
    end
  end

  // ---------------- smoothing step ----------------
  logic [SW_W-1:0] smooth_r;
  logic [SW_W-1:0] tgt, s_step, step_gap, snap_lim, smooth_nxt;
  logic [SW_W:0]   dn_sum;

  always_comb begin
    tgt      = {rpm_r, {FRAC_BITS{1'b0}}};
    snap_lim = SW_W'(tns_pkg::SNAP_RPM) << FRAC_BITS;
    // moving down rounds the step away from zero (floor of a negative quarter)
    dn_sum   = {1'b0, smooth_r - tgt} + (SW_W + 1)'(3);
    if (tgt >= smooth_r) begin
      s_step = smooth_r + ((tgt - smooth_r) >> 2);
    end else begin
      s_step = smooth_r - {1'b0, dn_sum[SW_W:2]};
    end
    step_gap   = (tgt >= s_step) ? (tgt - s_step) : (s_step - tgt);
    smooth_nxt = (step_gap < snap_lim) ? tgt : s_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= '0;
    end else if (state_r == tns_pkg::ST_SMOOTH) begin
      smooth_r <= smooth_nxt;
    end
  end

  // ---------------- zone, shift light, readout ----------------
  logic [tns_pkg::ZONE_W-1:0]    zone_r;
  logic                          lit_r;
  logic [tns_pkg::RDQ_W-1:0]     rdq_r;
  logic [tns_pkg::READOUT_W-1:0] readout_r;
  logic [tns_pkg::READOUT_W-1:0] rd_sum;
  logic [RDP_W-1:0]              rd_prod;

  assign rd_sum  = tns_pkg::READOUT_W'(rpm_r) + tns_pkg::READOUT_W'(tns_pkg::READOUT_HALF);
  assign rd_prod = RDP_W'(rd_sum) * RDP_W'(tns_pkg::RECIP_MUL);

  always_ff @(posedge clk) begin
    if (state_r == tns_pkg::ST_SMOOTH) begin
      // red wins over amber regardless of threshold order
      lit_r  <= (rpm_r >= red_r);
      zone_r <= (rpm_r >= red_r)   ? tns_pkg::ZONE_RED :
                (rpm_r >= amber_r) ? tns_pkg::ZONE_AMBER : tns_pkg::ZONE_NORMAL;
      rdq_r  <= rd_prod[tns_pkg::RECIP_SHIFT +: tns_pkg::RDQ_W];
    end
    if (state_r == tns_pkg::ST_SCALE) begin
      readout_r <= tns_pkg::READOUT_W'(tns_pkg::READOUT_W'(rdq_r) *
                                       tns_pkg::READOUT_W'(tns_pkg::READOUT_STEP));
    end
  end

  // ---------------- angle: round(S*sweep / (max<<F)) ----------------
  logic [PW-1:0] prod_r;
  logic [WW-1:0] div_num, div_dvs;

  always_ff @(posedge clk) begin
    if (state_r == tns_pkg::ST_SCALE) begin
      prod_r <= PW'(smooth_r) * PW'(SWEEP_TENTHS);
    end
  end

  // (2*S*sweep + den) / (2*den), den = max << F
  assign div_num = WW'({prod_r, 1'b0}) + WW'({gmax_r, {FRAC_BITS{1'b0}}});
  assign div_dvs = WW'({gmax_r, {(FRAC_BITS + 1){1'b0}}});

  tns_div #(
    .WW (WW),
    .QW (QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .dvs   (div_dvs),
    .done  (div_done),
    .quot  (div_quot)
  );

  // quotient top bit set means at least 2^ANGLE_W: saturates with the rest
  logic [tns_pkg::ANGLE_W-1:0] angle;

  always_comb begin
    if (gmax_r == '0) begin
      angle = '0;
    end else if (div_quot > QW'(LIM)) begin
      angle = tns_pkg::ANGLE_W'(LIM);
    end else begin
      angle = div_quot[tns_pkg::ANGLE_W-1:0];
    end
  end

  // ---------------- history and output register ----------------
  logic                          hist_r;
  logic [tns_pkg::ANGLE_W-1:0]   last_angle_r;
  logic [tns_pkg::ZONE_W-1:0]    last_zone_r;
  logic [tns_pkg::READOUT_W-1:0] last_readout_r;
  logic                          shift_r;
  logic                          out_valid_r;
  logic                          finish;

  assign finish    = (state_r == tns_pkg::ST_DONE) && out_free;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r         <= 1'b0;
      last_angle_r   <= '0;
      last_zone_r    <= tns_pkg::ZONE_NORMAL;
      last_readout_r <= '0;
      shift_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (finish) begin
        hist_r         <= 1'b1;
        last_angle_r   <= angle;
        last_zone_r    <= zone_r;
        last_readout_r <= readout_r;
        shift_r        <= lit_r;
        out_valid_r    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_needle_angle    <= angle;
      out_angle_changed   <= !hist_r || (angle != last_angle_r);
      out_speed_zone      <= zone_r;
      out_zone_changed    <= !hist_r || (zone_r != last_zone_r);
      out_readout_value   <= readout_r;
      out_readout_changed <= !hist_r || (readout_r != last_readout_r);
      out_shift_light     <= lit_r;
      out_shift_changed   <= !hist_r || (lit_r != shift_r);
    end
  end

endmodule

// File: rtl/tns_div.sv
// tns_div: iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; sized by the core.
module tns_div #(
  parameter int WW = 48,
  parameter int QW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [WW-1:0] num,
  input  logic [WW-1:0] dvs,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int CW = (QW > 1) ? $clog2(QW) : 1;

  logic          busy_r;
  logic          done_r;
  logic [WW-1:0] rem_r;
  logic [WW-1:0] dvs_r;
  logic [QW-1:0] quot_r;
  logic [CW-1:0] cnt_r;
  logic          fit;

  assign fit  = (rem_r >= dvs_r);
  assign done = done_r;
  assign quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      dvs_r  <= dvs << (QW - 1);
      quot_r <= '0;
      cnt_r  <= CW'(QW - 1);
    end else if (busy_r) begin
      if (fit) begin
        rem_r <= rem_r - dvs_r;
      end
      quot_r <= {quot_r[QW-2:0], fit};
      dvs_r  <= dvs_r >> 1;
      cnt_r  <= cnt_r - CW'(1);
    end
  end

endmodule

// File: rtl/tns_checker.sv
// tns_checker: port-level assertions for the tachometer needle smoother core,
// bound to the top level below. Depends on tns_pkg.
module tns_checker #(
  parameter int SWEEP_TENTHS = tns_pkg::SWEEP_TENTHS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [tns_pkg::ANGLE_W-1:0]         out_needle_angle,
  input logic [tns_pkg::ZONE_W-1:0]          out_speed_zone,
  input logic [tns_pkg::READOUT_W-1:0]       out_readout_value,
  input logic                                out_shift_light
);

  localparam int LIM = (SWEEP_TENTHS > tns_pkg::ANGLE_MAX) ?
                       tns_pkg::ANGLE_MAX : SWEEP_TENTHS;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_needle_angle) &&
    $stable(out_speed_zone) && $stable(out_readout_value))
    else $error("result changed while stalled");

  // one sample at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a sample while busy");

  // angle never passes full sweep
  a_angle_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_needle_angle <= tns_pkg::ANGLE_W'(LIM))
    else $error("needle angle beyond sweep");

  // shift light and red zone agree
  a_light_zone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_shift_light == (out_speed_zone == tns_pkg::ZONE_RED)) &&
    (out_speed_zone == tns_pkg::ZONE_NORMAL || out_speed_zone == tns_pkg::ZONE_AMBER ||
     out_speed_zone == tns_pkg::ZONE_RED))
    else $error("shift light disagrees with zone");

endmodule

bind tachometer_needle_smoother_core tns_checker #(
  .SWEEP_TENTHS (SWEEP_TENTHS)
) u_tns_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_needle_angle  (out_needle_angle),
  .out_speed_zone    (out_speed_zone),
  .out_readout_value (out_readout_value),
  .out_shift_light   (out_shift_light)
);
